### hw/rtl/ntnu_pkg.sv
// ----------------------------------------------------------------------------
// ntnu_pkg
// Shared types, character constants and the code table of the nibble unpacker.
// ----------------------------------------------------------------------------
package ntnu_pkg;

    localparam int CHAR_W      = 8;
    localparam int CODE_W      = 4;
    localparam int MAX_CHARS   = 4;
    localparam int SLOT_W      = $clog2(MAX_CHARS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CODE_W-1:0] CODE_END = 4'hF;

    localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI = 8'h40;
    localparam logic [CHAR_W-1:0] CHAR_DOT      = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_NL       = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_PLUS     = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOLLAR   = 8'h24;
    localparam logic [CHAR_W-1:0] CHAR_E        = 8'h65;

    // one classified input byte: up to four characters in output order
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [SLOT_W-1:0]                last_slot;
        logic                             stream_end;
    } ntnu_entry_t;

    // front side status
    typedef struct packed {
        logic push;
        logic finished;
    } ntnu_front_stat_t;

    // queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } ntnu_queue_stat_t;

    // 4-bit code to ascii character
    function automatic logic [CHAR_W-1:0] code_char(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            4'hA:    ch = CHAR_DOT;
            4'hB:    ch = CHAR_NL;
            4'hC:    ch = CHAR_PLUS;
            4'hD:    ch = CHAR_MINUS;
            4'hE:    ch = CHAR_SPACE;
            4'hF:    ch = CHAR_DOLLAR;
            default: ch = CHAR_DIGIT_LO | {{(CHAR_W-CODE_W){1'b0}}, code};
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
        return (ch >= CHAR_DIGIT_LO) && (ch < CHAR_DIGIT_HI);
    endfunction

endpackage

### hw/rtl/ntnu_byte_if.sv
// ----------------------------------------------------------------------------
// ntnu_byte_if
// Channel carrying one packed byte per beat.
// ----------------------------------------------------------------------------
interface ntnu_byte_if;

    logic                         valid;
    logic                         ready;
    logic [ntnu_pkg::CHAR_W-1:0]  packed_byte;

    modport source (output valid, output packed_byte, input ready);
    modport sink   (input valid, input packed_byte, output ready);

endinterface

### hw/rtl/ntnu_char_if.sv
// ----------------------------------------------------------------------------
// ntnu_char_if
// Channel carrying one restored character per beat.
// ----------------------------------------------------------------------------
interface ntnu_char_if;

    logic                         valid;
    logic                         ready;
    logic [ntnu_pkg::CHAR_W-1:0]  out_char;
    logic                         last_of_run;
    logic                         stream_end;

    modport source (output valid, output out_char, output last_of_run, output stream_end,
                    input ready);
    modport sink   (input valid, input out_char, input last_of_run, input stream_end,
                    output ready);

endinterface

### hw/rtl/ntnu_front.sv
// ----------------------------------------------------------------------------
// ntnu_front
// Accepts packed bytes, expands the nibbles into characters with the
// exponent 'e' inserted, and pushes one entry per byte into the queue until the stream ends.
// ----------------------------------------------------------------------------
module ntnu_front (
    input  logic                        clk,
    input  logic                        rst_n,
    ntnu_byte_if.sink                   in_bus,
    input  ntnu_pkg::ntnu_queue_stat_t  queue_stat,
    output ntnu_pkg::ntnu_front_stat_t  front_stat,
    output ntnu_pkg::ntnu_entry_t       entry
);
    import ntnu_pkg::*;

    logic                prev_digit_reg;
    logic                prev_digit_next;
    logic                finished_reg;
    logic                finished_next;
    logic                accept;
    logic [CODE_W-1:0]   hi_code;
    logic [CODE_W-1:0]   lo_code;
    logic [CHAR_W-1:0]   hi_char;
    logic [CHAR_W-1:0]   lo_char;
    logic                hi_digit;
    logic                lo_digit;
    logic                hi_e;
    logic                lo_e;
    logic                end_here;
    logic [SLOT_W:0]     slot;

    // bytes after the end are taken and dropped
    assign in_bus.ready = finished_reg | ~queue_stat.full;
    assign accept       = in_bus.valid & in_bus.ready;

    // classify both nibbles
    assign hi_code  = in_bus.packed_byte[CHAR_W-1:CODE_W];
    assign lo_code  = in_bus.packed_byte[CODE_W-1:0];
    assign hi_char  = code_char(hi_code);
    assign lo_char  = code_char(lo_code);
    assign hi_digit = is_digit(hi_char);
    assign lo_digit = is_digit(lo_char);
    assign hi_e     = (hi_char == CHAR_PLUS) | ((hi_char == CHAR_MINUS) & prev_digit_reg);
    assign lo_e     = (lo_char == CHAR_PLUS) | ((lo_char == CHAR_MINUS) & hi_digit);
    assign end_here = (lo_code == CODE_END);

    // place characters in output order
    always_comb
    begin
        entry.chars = '0;
        slot        = '0;
        if (hi_e)
        begin
            entry.chars[slot[SLOT_W-1:0]] = CHAR_E;
            slot = slot + 1'b1;
        end
        entry.chars[slot[SLOT_W-1:0]] = hi_char;
        slot = slot + 1'b1;
        if (!end_here)
        begin
            if (lo_e)
            begin
                entry.chars[slot[SLOT_W-1:0]] = CHAR_E;
                slot = slot + 1'b1;
            end
            entry.chars[slot[SLOT_W-1:0]] = lo_char;
            slot = slot + 1'b1;
        end
        entry.last_slot  = SLOT_W'(slot - 1'b1);
        entry.stream_end = end_here;
    end

    // stream state
    always_comb
    begin
        prev_digit_next = prev_digit_reg;
        finished_next   = finished_reg;
        if (accept && !finished_reg)
        begin
            prev_digit_next = end_here ? hi_digit : lo_digit;
            finished_next   = end_here;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_digit_reg <= 1'b0;
            finished_reg   <= 1'b0;
        end
        else
        begin
            prev_digit_reg <= prev_digit_next;
            finished_reg   <= finished_next;
        end
    end

    assign front_stat.push     = accept & ~finished_reg;
    assign front_stat.finished = finished_reg;

endmodule

### hw/rtl/ntnu_queue.sv
// ----------------------------------------------------------------------------
// ntnu_queue
// Short first-in first-out queue of expanded entries between front and back.
// ----------------------------------------------------------------------------
module ntnu_queue #(
    parameter int DEPTH = ntnu_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ntnu_pkg::ntnu_front_stat_t  front_stat,
    input  ntnu_pkg::ntnu_entry_t       wr_entry,
    input  logic                        pop,
    output ntnu_pkg::ntnu_queue_stat_t  queue_stat,
    output ntnu_pkg::ntnu_entry_t       rd_entry
);
    import ntnu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ntnu_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;

    assign push = front_stat.push;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry         = mem_reg[rd_ptr_reg];
    assign queue_stat.full  = (count_reg == FULL_CNT);
    assign queue_stat.empty = (count_reg == '0);

endmodule

### hw/rtl/ntnu_back.sv
// ----------------------------------------------------------------------------
// ntnu_back
// Walks the head entry into the output register, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module ntnu_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ntnu_pkg::ntnu_queue_stat_t  queue_stat,
    input  ntnu_pkg::ntnu_entry_t       head,
    output logic                        pop,
    ntnu_char_if.source                 out_bus
);
    import ntnu_pkg::*;

    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic               valid_reg;
    logic               valid_next;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic               end_reg;
    logic               load;
    logic               at_last;

    // fill the output register whenever the queue has an entry and the register is empty or being drained
    assign load    = ~queue_stat.empty & (~valid_reg | out_bus.ready);
    assign at_last = (slot_reg == head.last_slot);
    assign pop     = load & at_last;

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg & ~out_bus.ready;
        if (load)
        begin
            valid_next = 1'b1;
            slot_next  = at_last ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head.chars[slot_reg];
            last_reg <= at_last;
            end_reg  <= head.stream_end;
        end
    end

    assign out_bus.valid       = valid_reg;
    assign out_bus.out_char    = char_reg;
    assign out_bus.last_of_run = last_reg;
    assign out_bus.stream_end  = end_reg;

endmodule

### hw/rtl/numeric_text_nibble_unpacker.sv
// ----------------------------------------------------------------------------
// numeric_text_nibble_unpacker
// Unpacks two 4-bit character codes per byte into restored numeric text.
// ----------------------------------------------------------------------------
// Each input beat is one packed byte, high nibble first. It yields one to four
// output beats (digits, '.', newline, '+', '-', space, '$', with an 'e' placed
// before every '+' and before a '-' that follows a digit). The output delivers
// one character per cycle unless the queue is empty or the output is stalled.
// That rate is set by the single output register in the back end; the front
// end expands a byte combinationally as it is accepted and parks it in a short
// queue, so input and output stall independently. A '$' in the low nibble ends
// the stream: the byte's characters carry stream_end, and every later byte is
// taken and dropped until reset.
// ----------------------------------------------------------------------------
module numeric_text_nibble_unpacker #(
    parameter int QUEUE_DEPTH = ntnu_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    ntnu_byte_if.sink    in_bus,
    ntnu_char_if.source  out_bus
);
    import ntnu_pkg::*;

    ntnu_front_stat_t  front_stat;
    ntnu_queue_stat_t  queue_stat;
    ntnu_entry_t       wr_entry;
    ntnu_entry_t       head;
    logic              pop;

    // byte intake and expansion
    ntnu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_bus     (in_bus),
        .queue_stat (queue_stat),
        .front_stat (front_stat),
        .entry      (wr_entry)
    );

    // decoupling queue
    ntnu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .front_stat (front_stat),
        .wr_entry   (wr_entry),
        .pop        (pop),
        .queue_stat (queue_stat),
        .rd_entry   (head)
    );

    // character output
    ntnu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .queue_stat (queue_stat),
        .head       (head),
        .pop        (pop),
        .out_bus    (out_bus)
    );

    // a full queue never takes an entry
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.push |-> !queue_stat.full)
        else $error("queue written while full");

    // an empty queue is never popped
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_stat.empty)
        else $error("queue popped while empty");

    // the final beat of a terminated byte implies the stream is closed
    a_end_closes_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (out_bus.valid && out_bus.ready && out_bus.last_of_run && out_bus.stream_end)
            |-> front_stat.finished)
        else $error("terminator delivered while stream still open");

    // once closed the front end queues nothing more
    a_closed_stays_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.finished |-> !front_stat.push)
        else $error("byte queued after end of stream");

endmodule
